### src/hfsc_pkg.sv
// ----------------------------------------------------------------------------
// hfsc_pkg
// Shared types, widths and constants of the heatsink fan speed curve block.
// ----------------------------------------------------------------------------
package hfsc_pkg;

  // field and datapath widths
  localparam int TEMP_W  = 16;
  localparam int SPEED_W = 7;
  localparam int CNT_W   = 32;
  localparam int ECO_W   = 16;
  localparam int TMO_W   = 20;
  localparam int MUL_W   = 26;
  localparam int NUM_W   = 24;
  localparam int DEN_W   = 17;
  localparam int DSH_W   = DEN_W + SPEED_W - 1;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 20;

  // speed and counter constants
  localparam logic [SPEED_W-1:0] SPEED_FULL = 7'd100;
  localparam logic [SPEED_W-1:0] SPEED_STOP = 7'd0;
  localparam logic [CNT_W-1:0]   CNT_MAX    = 32'hFFFF_FFFF;
  localparam logic [9:0]         MS_PER_S   = 10'd1000;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_CTRL_EN     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ECO_ENABLE  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_SPEED   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TEMP_LOW    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TEMP_HIGH   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ECO_SECONDS = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_MS  = 3'd6;

  // configuration register file contents
  typedef struct packed {
    logic                     ctrl_en;
    logic                     eco_mode_enable;
    logic [SPEED_W-1:0]       min_fan_speed;
    logic signed [TEMP_W-1:0] temp_low;
    logic signed [TEMP_W-1:0] temp_high;
    logic [ECO_W-1:0]         eco_cooling_seconds;
    logic [TMO_W-1:0]         sensor_timeout_ms;
  } cfg_t;

  // divider status
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

### src/hfsc_in_if.sv
// ----------------------------------------------------------------------------
// hfsc_in_if
// Tick channel: drive flag and optional sensor sample, valid/ready.
// ----------------------------------------------------------------------------
interface hfsc_in_if
  import hfsc_pkg::*;
;
  logic                     valid;
  logic                     ready;
  logic                     drive_active;
  logic                     sample_present;
  logic                     sample_ok;
  logic signed [TEMP_W-1:0] sample_temp;

  modport source (output valid, drive_active, sample_present, sample_ok, sample_temp,
                  input ready);
  modport sink   (input valid, drive_active, sample_present, sample_ok, sample_temp,
                  output ready);
endinterface

### src/hfsc_out_if.sv
// ----------------------------------------------------------------------------
// hfsc_out_if
// Result channel: fan speed command and temperature status, valid/ready.
// ----------------------------------------------------------------------------
interface hfsc_out_if
  import hfsc_pkg::*;
;
  logic                     valid;
  logic                     ready;
  logic [SPEED_W-1:0]       fan_speed;
  logic                     fan_running;
  logic                     temp_available;
  logic signed [TEMP_W-1:0] temp_report;

  modport source (output valid, fan_speed, fan_running, temp_available, temp_report,
                  input ready);
  modport sink   (input valid, fan_speed, fan_running, temp_available, temp_report,
                  output ready);
endinterface

### src/hfsc_cfg.sv
// ----------------------------------------------------------------------------
// hfsc_cfg
// Configuration register file, written through a plain write port.
// ----------------------------------------------------------------------------
module hfsc_cfg
  import hfsc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output cfg_t                  cfg
);

  // register writes, unknown indexes dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.ctrl_en             <= 1'b0;
      cfg.eco_mode_enable     <= 1'b0;
      cfg.min_fan_speed       <= '0;
      cfg.temp_low            <= 16'sd7680;
      cfg.temp_high           <= 16'sd15360;
      cfg.eco_cooling_seconds <= '0;
      cfg.sensor_timeout_ms   <= 20'd1000;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_CTRL_EN:     cfg.ctrl_en             <= cfg_data[0];
        REG_ECO_ENABLE:  cfg.eco_mode_enable     <= cfg_data[0];
        REG_MIN_SPEED:   cfg.min_fan_speed       <= cfg_data[SPEED_W-1:0];
        REG_TEMP_LOW:    cfg.temp_low            <= cfg_data[TEMP_W-1:0];
        REG_TEMP_HIGH:   cfg.temp_high           <= cfg_data[TEMP_W-1:0];
        REG_ECO_SECONDS: cfg.eco_cooling_seconds <= cfg_data[ECO_W-1:0];
        REG_TIMEOUT_MS:  cfg.sensor_timeout_ms   <= cfg_data[TMO_W-1:0];
        default: begin
        end
      endcase
    end
  end

endmodule

### src/hfsc_div.sv
// ----------------------------------------------------------------------------
// hfsc_div
// Restoring divider: one shared compare-subtract per cycle, seven quotient
// bits, quotient known to stay below 128.
// ----------------------------------------------------------------------------
module hfsc_div
  import hfsc_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [NUM_W-1:0]   num,
  input  logic [DEN_W-1:0]   den,
  output logic [SPEED_W-1:0] quot,
  output div_stat_t          stat
);

  logic [NUM_W-1:0] rem;
  logic [DSH_W-1:0] dsh;
  logic [2:0]       cnt;
  logic             fits;

  // shared compare for the current quotient bit
  assign fits = rem >= NUM_W'(dsh);

  always_ff @(posedge clk) begin
    if (rst) begin
      stat.busy <= 1'b0;
      stat.done <= 1'b0;
      cnt       <= '0;
    end else if (start) begin
      stat.busy <= 1'b1;
      stat.done <= 1'b0;
      cnt       <= 3'(SPEED_W - 1);
    end else if (stat.busy) begin
      if (cnt == '0) begin
        stat.busy <= 1'b0;
        stat.done <= 1'b1;
      end else begin
        stat.done <= 1'b0;
        cnt       <= cnt - 3'd1;
      end
    end else begin
      stat.done <= 1'b0;
    end
  end

  // remainder, shifted divisor and quotient
  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= num;
      dsh  <= {den, {(SPEED_W-1){1'b0}}};
      quot <= '0;
    end else if (stat.busy) begin
      if (fits) begin
        rem <= rem - NUM_W'(dsh);
      end
      dsh  <= dsh >> 1;
      quot <= {quot[SPEED_W-2:0], fits};
    end
  end

endmodule

### src/heatsink_fan_speed_curve_top.sv
// ----------------------------------------------------------------------------
// heatsink_fan_speed_curve_top
// Fan speed from heatsink temperature, one result per millisecond tick.
//
//   channel    dir  handshake     payload
//   sample_ch  in   valid/ready   drive_active, sample_present, sample_ok,
//                                 sample_temp
//   speed_ch   out  valid/ready   fan_speed, fan_running, temp_available,
//                                 temp_report
//   cfg        in   cfg_we        cfg_index, cfg_data
//
// A tick's result is registered on speed_ch after the MUL, EVAL and DONE
// states, with a DIV state before DONE when the curve is interpolated: the
// shared compare-subtract divider forms its quotient, which DIV picks up on done.
// sample_ch is ready again as soon as the result is registered; no new tick is
// taken while the previous one is still being worked out.
// One shared multiplier serves both the curve product and the eco hold time.
// rst is synchronous, clears counters and temperature state and resets config to its defaults.
// sample_ch is ready only while the sequencer is idle; a result waiting on
// speed_ch does not block the next transfer, but holds the next result.
// ----------------------------------------------------------------------------
module heatsink_fan_speed_curve_top
  import hfsc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  hfsc_in_if.sink               sample_ch,
  hfsc_out_if.source            speed_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  typedef enum logic [2:0] {IDLE, MUL, EVAL, DIV, DONE} state_t;

  state_t                   state;
  cfg_t                     cfg;
  div_stat_t                div_stat;

  logic signed [TEMP_W-1:0] last_temp;
  logic                     temp_valid;
  logic [CNT_W-1:0]         ms_since_reading;
  logic [CNT_W-1:0]         ms_since_drive_ran;
  logic                     drive;
  logic [MUL_W-1:0]         prod;
  logic [SPEED_W-1:0]       speed;

  logic                     accept;
  logic [SPEED_W-1:0]       lo_speed;
  logic [SPEED_W-1:0]       span_s;
  logic signed [TEMP_W:0]   span_full;
  logic signed [TEMP_W:0]   pos_full;
  logic [TEMP_W-1:0]        span_t;
  logic [TEMP_W-1:0]        pos_t;
  logic                     eco_path;
  logic [TEMP_W-1:0]        mul_a;
  logic [9:0]               mul_b;
  logic                     timed_out;
  logic                     at_low;
  logic                     at_high;
  logic                     div_start;
  logic [NUM_W-1:0]         div_num;
  logic [DEN_W-1:0]         div_den;
  logic [SPEED_W-1:0]       div_quot;
  logic                     out_free;

  hfsc_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  hfsc_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .quot  (div_quot),
    .stat  (div_stat)
  );

  assign accept          = sample_ch.valid && sample_ch.ready;
  assign sample_ch.ready = (state == IDLE);
  assign out_free        = !speed_ch.valid || speed_ch.ready;

  // curve terms from the updated tick state
  assign lo_speed  = (cfg.min_fan_speed > SPEED_FULL) ? SPEED_FULL : cfg.min_fan_speed;
  assign span_s    = SPEED_FULL - lo_speed;
  assign span_full = 17'(cfg.temp_high) - 17'(cfg.temp_low);
  assign pos_full  = 17'(last_temp) - 17'(cfg.temp_low);
  assign span_t    = span_full[TEMP_W-1:0];
  assign pos_t     = pos_full[TEMP_W-1:0];
  assign eco_path  = cfg.eco_mode_enable && !drive;
  assign timed_out = !temp_valid && (ms_since_reading > CNT_W'(cfg.sensor_timeout_ms));
  assign at_low    = last_temp <= cfg.temp_low;
  assign at_high   = last_temp >= cfg.temp_high;

  // shared multiplier operands: eco hold time or curve product
  assign mul_a = eco_path ? cfg.eco_cooling_seconds : pos_t;
  assign mul_b = eco_path ? MS_PER_S : 10'(span_s);

  // divider operands: (2*pos*span_s + span_t) / (2*span_t)
  assign div_num   = {prod[NUM_W-2:0], 1'b0} + NUM_W'(span_t);
  assign div_den   = {span_t, 1'b0};
  assign div_start = (state == EVAL) && cfg.ctrl_en && !eco_path && !timed_out &&
                     !at_low && !at_high;

  // tick state: counters, last temperature, availability
  always_ff @(posedge clk) begin
    if (rst) begin
      last_temp          <= '0;
      temp_valid         <= 1'b0;
      ms_since_reading   <= '0;
      ms_since_drive_ran <= '0;
      drive              <= 1'b0;
    end else if (accept) begin
      drive <= sample_ch.drive_active;
      if (sample_ch.drive_active) begin
        ms_since_drive_ran <= '0;
      end else if (ms_since_drive_ran != CNT_MAX) begin
        ms_since_drive_ran <= ms_since_drive_ran + 32'd1;
      end
      if (sample_ch.sample_present && sample_ch.sample_ok) begin
        last_temp        <= sample_ch.sample_temp;
        temp_valid       <= 1'b1;
        ms_since_reading <= '0;
      end else begin
        if (sample_ch.sample_present) begin
          temp_valid <= 1'b0;
        end
        if (ms_since_reading != CNT_MAX) begin
          ms_since_reading <= ms_since_reading + 32'd1;
        end
      end
    end
  end

  // sequencer and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= IDLE;
      speed_ch.valid <= 1'b0;
    end else begin
      if ((state == DONE) && out_free) begin
        speed_ch.valid <= 1'b1;
      end else if (speed_ch.valid && speed_ch.ready) begin
        speed_ch.valid <= 1'b0;
      end
      unique case (state)
        IDLE: begin
          if (accept) begin
            state <= MUL;
          end
        end
        MUL: begin
          prod  <= MUL_W'(mul_a * mul_b);
          state <= EVAL;
        end
        EVAL: begin
          if (!cfg.ctrl_en) begin
            speed <= SPEED_STOP;
            state <= DONE;
          end else if (eco_path) begin
            speed <= (ms_since_drive_ran >= CNT_W'(prod)) ? SPEED_STOP : lo_speed;
            state <= DONE;
          end else if (timed_out) begin
            speed <= SPEED_FULL;
            state <= DONE;
          end else if (at_low) begin
            speed <= lo_speed;
            state <= DONE;
          end else if (at_high) begin
            speed <= SPEED_FULL;
            state <= DONE;
          end else begin
            state <= DIV;
          end
        end
        DIV: begin
          if (div_stat.done) begin
            speed <= lo_speed + div_quot;
            state <= DONE;
          end
        end
        DONE: begin
          if (out_free) begin
            speed_ch.fan_speed      <= speed;
            speed_ch.fan_running    <= (speed != SPEED_STOP);
            speed_ch.temp_available <= temp_valid;
            speed_ch.temp_report    <= last_temp;
            state                   <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

  // checks
  a_running_matches: assert property (@(posedge clk) disable iff (rst)
    speed_ch.valid |-> (speed_ch.fan_running == (speed_ch.fan_speed != SPEED_STOP)))
    else $error("fan_running disagrees with fan_speed");

  a_speed_range: assert property (@(posedge clk) disable iff (rst)
    speed_ch.valid |-> (speed_ch.fan_speed <= SPEED_FULL))
    else $error("fan_speed above full scale");

  a_div_in_div: assert property (@(posedge clk) disable iff (rst)
    div_stat.done |-> (state == DIV))
    else $error("divider finished outside the divide step");

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == MUL))
    else $error("transfer did not start the sequencer");

  a_div_idle_start: assert property (@(posedge clk) disable iff (rst)
    div_start |-> !div_stat.busy)
    else $error("divider restarted while busy");

endmodule
